/* rtl/idf_pkg.sv */
// package: payload and config types, register indexes, status and phase codes
`timescale 1ns / 1ps

package idf_pkg;

   // register indexes on the csr port
   localparam int unsigned CsrIdxWidth = 3;
   localparam logic [CsrIdxWidth-1:0] REG_TIMEOUT_MS = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_ID_0       = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_ID_1       = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_ID_2       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_ID_3       = 3'd4;
   localparam int unsigned CsrDataWidth = 16;

   // register reset values
   localparam logic [15:0] TIMEOUT_RESET = 16'd2500;
   localparam logic [7:0]  ID_0_RESET    = 8'h31;
   localparam logic [7:0]  ID_1_RESET    = 8'h32;
   localparam logic [7:0]  ID_2_RESET    = 8'h33;
   localparam logic [7:0]  ID_3_RESET    = 8'h34;

   // result status codes
   localparam logic [1:0] ST_BYTE  = 2'd0;
   localparam logic [1:0] ST_LAST  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_ABORT = 2'd3;

   // parser phase
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_LEN_LO = 4'b0010,
      PH_LEN_HI = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  frame_id;
      logic [7:0]  payload_byte;
      logic [15:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [7:0]  accepted_id_0;
      logic [7:0]  accepted_id_1;
      logic [7:0]  accepted_id_2;
      logic [7:0]  accepted_id_3;
   } cfg_type;

endpackage

/* rtl/idf_parser.sv */
// frame parser: phase state, length tracking, timeout check and result decode
`timescale 1ns / 1ps

module idf_parser (
   input  logic             clock,
   input  logic             reset,
   input  idf_pkg::cfg_type cfg,
   input  idf_pkg::req_type beat,
   input  logic             step_en,
   output logic             res_valid,
   output idf_pkg::rsp_type res
);
   import idf_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cur_id_ff, cur_id_in;
   logic [15:0] decl_ff, decl_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] start_ff, start_in;
   logic        armed_ff, armed_in;

   logic [31:0] elapsed;
   logic        expired;
   phase_type   phase_eff;
   logic [15:0] count_eff;
   logic        armed_eff;
   logic        id_match;

   // timeout check against the stamp of the id beat
   assign elapsed  = beat.now_ms - start_ff;
   assign expired  = armed_ff && (elapsed > {16'd0, cfg.timeout_ms});
   assign id_match = (beat.rx_byte == cfg.accepted_id_0) ||
                     (beat.rx_byte == cfg.accepted_id_1) ||
                     (beat.rx_byte == cfg.accepted_id_2) ||
                     (beat.rx_byte == cfg.accepted_id_3);

   // state after a possible abort, then the beat is parsed from there
   always_comb begin
      phase_eff = expired ? PH_IDLE : phase_ff;
      count_eff = expired ? 16'd0 : count_ff;
      armed_eff = expired ? 1'b0 : armed_ff;

      phase_in  = phase_eff;
      cur_id_in = cur_id_ff;
      decl_in   = decl_ff;
      count_in  = count_eff;
      start_in  = start_ff;
      armed_in  = armed_eff;

      res_valid        = 1'b0;
      res.status       = ST_ABORT;
      res.frame_id     = cur_id_ff;
      res.payload_byte = 8'd0;
      res.frame_length = decl_ff;

      // abort of an open frame
      if (expired && (phase_ff != PH_IDLE)) begin
         res_valid = 1'b1;
      end

      unique case (phase_eff)
         PH_IDLE: begin
            if (id_match) begin
               cur_id_in = beat.rx_byte;
               decl_in   = 16'd0;
               count_in  = 16'd0;
               start_in  = beat.now_ms;
               armed_in  = 1'b1;
               phase_in  = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            decl_in  = {8'd0, beat.rx_byte};
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            decl_in  = {beat.rx_byte, decl_ff[7:0]};
            count_in = 16'd0;
            if (decl_in == 16'd0) begin
               res_valid        = 1'b1;
               res.status       = ST_EMPTY;
               res.frame_length = decl_in;
               phase_in         = PH_IDLE;
               armed_in         = 1'b0;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            count_in         = count_eff + 16'd1;
            res_valid        = 1'b1;
            res.payload_byte = beat.rx_byte;
            if (count_in >= decl_ff) begin
               res.status = ST_LAST;
               phase_in   = PH_IDLE;
               count_in   = 16'd0;
               armed_in   = 1'b0;
            end else begin
               res.status = ST_BYTE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            armed_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         armed_ff <= 1'b0;
         count_ff <= 16'd0;
         cur_id_ff <= 8'd0;
         decl_ff  <= 16'd0;
         start_ff <= 32'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
         cur_id_ff <= cur_id_in;
         decl_ff  <= decl_in;
         start_ff <= start_in;
      end
   end

   // timer runs exactly while a frame is open
   a_armed_open: assert property (@(posedge clock) disable iff (reset)
      armed_ff == (phase_ff != PH_IDLE))
      else $error("timer armed state disagrees with frame phase");

   // data phase never has counted the whole frame yet
   a_count_below: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (count_ff < decl_ff))
      else $error("byte count reached declared length inside data phase");

   // an empty-frame result carries zero length
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status == ST_EMPTY)) |-> (res.frame_length == 16'd0))
      else $error("empty-frame result with nonzero length");

endmodule

/* rtl/id_length_frame_deframer.sv */
// top level: input register, csr registers, parser and result register
`timescale 1ns / 1ps

// channel | ports                             | beat
// req     | req_valid, req_stall, req_data    | one received byte with its ms stamp
// rsp     | rsp_valid, rsp_stall, rsp_data    | one result (payload, last, empty, abort)
// csr     | csr_valid, csr_ready, csr_index,  | one register write, csr_ready always high
//         | csr_data                          |
//
// one byte per cycle sustained while no result is held by rsp_stall: a beat waits in the input
// register, is parsed there and its result is registered in the result register.
// the limit is the single parser step, a 32-bit subtract and compare plus a 16-bit count.
// a beat that gives no result never waits on the result side.
// reset is synchronous; it returns the parser to idle and the registers to defaults.
// rsp_stall holds the result register; req_stall rises only when the parsed beat
// would give a result and the result register is full and stalled.

module id_length_frame_deframer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  idf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output idf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [idf_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [idf_pkg::CsrDataWidth-1:0]    csr_data
);
   import idf_pkg::*;

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic    res_valid;
   rsp_type res;
   logic    out_free;
   logic    step_en;
   logic    req_take;

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms    <= TIMEOUT_RESET;
         cfg_ff.accepted_id_0 <= ID_0_RESET;
         cfg_ff.accepted_id_1 <= ID_1_RESET;
         cfg_ff.accepted_id_2 <= ID_2_RESET;
         cfg_ff.accepted_id_3 <= ID_3_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TIMEOUT_MS: cfg_ff.timeout_ms    <= csr_data;
            REG_ID_0:       cfg_ff.accepted_id_0 <= csr_data[7:0];
            REG_ID_1:       cfg_ff.accepted_id_1 <= csr_data[7:0];
            REG_ID_2:       cfg_ff.accepted_id_2 <= csr_data[7:0];
            REG_ID_3:       cfg_ff.accepted_id_3 <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // parser
   idf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .beat      (in_data_ff),
      .step_en   (step_en),
      .res_valid (res_valid),
      .res       (res)
   );

   // handshake between the two registers
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && (!res_valid || out_free);
   assign req_stall = in_valid_ff && !step_en;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step_en) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a result never overwrites one still held by a stall
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (step_en && res_valid) |-> !(out_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // a parsed beat with no result always leaves the input register
   a_no_result_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !res_valid) |-> step_en)
      else $error("beat without result held in input register");

   // a held result register was filled by a parser step
   a_fill_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff)) |-> $past(step_en && res_valid))
      else $error("result register set without a parser result");

endmodule
